>>> hw/rtl/rca_pkg.sv
package rca_pkg;

  // Field widths fixed by the interface
  localparam int VALUE_W   = 64;
  localparam int BASE_W    = 5;
  localparam int WIDTH_W   = 7;
  localparam int CHAR_W    = 8;

  // Characters per number never exceed this, whatever the store depth
  localparam int RESULT_LIMIT  = 64;
  localparam int MAX_CHARS_DEF = 64;

  // Long division: quotient bits resolved per cycle, slices per digit
  localparam int BITS_PER_CYCLE = 8;
  localparam int SLICES         = VALUE_W / BITS_PER_CYCLE;
  localparam int SLICE_W        = $clog2(SLICES);

  localparam logic              MODE_SIGNED = 1'b1;
  localparam logic [BASE_W-1:0] BASE_MIN    = 5'd2;
  localparam logic [BASE_W-1:0] BASE_MAX    = 5'd16;
  localparam logic [BASE_W-1:0] BASE_DEC    = 5'd10;
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2d;

  typedef struct packed {
    logic               mode;
    logic [VALUE_W-1:0] value;
    logic [BASE_W-1:0]  base;
    logic [WIDTH_W-1:0] min_width;
    logic [CHAR_W-1:0]  pad_char;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIVIDE,
    S_PAD,
    S_SIGN,
    S_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic div_last;
    logic wr_zero;
    logic wr_pad;
    logic wr_sign;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic value_zero;
    logic count_zero;
    logic below_width;
    logic negative;
    logic emit_done;
  } dp_status_t;

  // Lower-case hex digit for a remainder
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'd0, d};
    end else begin
      c = 8'h61 + {4'd0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/rca_ram.sv
module rca_ram
  #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
  )
  (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
  );

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/rca_ctrl.sv
module rca_ctrl
  import rca_pkg::*;
  (
    input  logic       clk,
    input  logic       rst,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctl_cmd_t   cmd
  );

  ctl_state_t         state;
  ctl_state_t         state_next;
  logic [SLICE_W-1:0] slice_cnt;
  logic [SLICE_W-1:0] slice_cnt_next;
  logic               slice_end;

  assign slice_end = (slice_cnt == SLICE_W'(SLICES - 1));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = status.value_zero ? S_PAD : S_DIVIDE;
      end
      S_DIVIDE: begin
        if (slice_end) begin
          state_next = S_CHECK;
        end
      end
      S_PAD: begin
        priority if (status.below_width) begin
          state_next = S_PAD;
        end else if (status.negative) begin
          state_next = S_SIGN;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_SIGN: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.emit_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd            = '0;
    in_ready       = 1'b0;
    slice_cnt_next = slice_cnt;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_CHECK: begin
        cmd.wr_zero = status.value_zero && status.count_zero;
      end
      S_DIVIDE: begin
        cmd.div_step   = 1'b1;
        cmd.div_last   = slice_end;
        slice_cnt_next = slice_end ? '0 : slice_cnt + 1'b1;
      end
      S_PAD: begin
        cmd.wr_pad = status.below_width;
      end
      S_SIGN: begin
        cmd.wr_sign = 1'b1;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      slice_cnt <= '0;
    end else begin
      state     <= state_next;
      slice_cnt <= slice_cnt_next;
    end
  end

  // Store empty and no read pending whenever a new transaction may be taken
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> status.emit_done)
    else $error("idle with characters still pending");

  // At most one store write source per cycle
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.div_last, cmd.wr_zero, cmd.wr_pad, cmd.wr_sign}))
    else $error("conflicting store writes");

  // A division starts only on a nonzero value
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK && state_next == S_DIVIDE |=> !status.value_zero)
    else $error("division started on zero");

endmodule

>>> hw/rtl/rca_dpath.sv
module rca_dpath
  import rca_pkg::*;
  #(
    parameter int MAX_CHARS = MAX_CHARS_DEF
  )
  (
    input  logic       clk,
    input  logic       rst,
    input  in_item_t   in_item,
    input  ctl_cmd_t   cmd,
    output dp_status_t status,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_item
  );

  localparam int CAP    = (MAX_CHARS < RESULT_LIMIT) ? MAX_CHARS : RESULT_LIMIT;
  localparam int CNT_W  = $clog2(CAP + 1);
  localparam int ADDR_W = $clog2(CAP);

  logic [VALUE_W-1:0] rem_value;
  logic [3:0]         part_rem;
  logic [BASE_W-1:0]  base_r;
  logic [CNT_W-1:0]   width_r;
  logic [CNT_W-1:0]   limit_r;
  logic [CHAR_W-1:0]  pad_r;
  logic               neg_r;
  logic [CNT_W-1:0]   char_count;
  logic               pend;
  logic               pend_last;

  logic [VALUE_W-1:0] div_value;
  logic [3:0]         div_rem;
  logic [VALUE_W-1:0] work;
  logic [3:0]         r;
  logic [4:0]         t;

  logic               is_signed;
  logic               in_neg;
  logic [BASE_W-1:0]  base_sat;
  logic [CNT_W-1:0]   width_sat;

  logic               keep_digit;
  logic               wr_en;
  logic [CHAR_W-1:0]  wr_data;
  logic               issue;
  logic               load;
  logic [CNT_W-1:0]   cnt_dec;
  logic [CHAR_W-1:0]  rd_data;

  // Eight restoring-division steps on the running value
  always_comb begin
    work = rem_value;
    r    = part_rem;
    t    = '0;
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      t    = {r, work[VALUE_W-1]};
      work = {work[VALUE_W-2:0], 1'b0};
      if (t >= base_r) begin
        t       = t - base_r;
        work[0] = 1'b1;
      end
      r = t[3:0];
    end
    div_value = work;
    div_rem   = r;
  end

  // Decode the incoming transaction
  always_comb begin
    is_signed = (in_item.mode == MODE_SIGNED);
    in_neg    = is_signed && in_item.value[VALUE_W-1];
    if (is_signed) begin
      base_sat = BASE_DEC;
    end else if (in_item.base < BASE_MIN) begin
      base_sat = BASE_MIN;
    end else if (in_item.base > BASE_MAX) begin
      base_sat = BASE_MAX;
    end else begin
      base_sat = in_item.base;
    end
    if (is_signed) begin
      width_sat = '0;
    end else if (in_item.min_width > WIDTH_W'(CAP)) begin
      width_sat = CNT_W'(CAP);
    end else begin
      width_sat = in_item.min_width[CNT_W-1:0];
    end
  end

  // Store write: digit, lone zero, pad or sign
  always_comb begin
    keep_digit = cmd.div_last && (char_count < limit_r);
    wr_en      = keep_digit || cmd.wr_zero || cmd.wr_pad || cmd.wr_sign;
    priority if (cmd.wr_zero) begin
      wr_data = CHAR_ZERO;
    end else if (cmd.wr_pad) begin
      wr_data = pad_r;
    end else if (cmd.wr_sign) begin
      wr_data = CHAR_MINUS;
    end else begin
      wr_data = digit_char(div_rem);
    end
  end

  // Read back in reverse, one read ahead of the output register
  assign load    = pend && (!out_valid || out_ready);
  assign issue   = cmd.emit && (char_count != '0) && (!pend || load);
  assign cnt_dec = char_count - 1'b1;

  rca_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CAP)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (char_count[ADDR_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (cnt_dec[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_value <= in_neg ? (VALUE_W'(0) - in_item.value) : in_item.value;
      part_rem  <= '0;
      base_r    <= base_sat;
      width_r   <= width_sat;
      limit_r   <= CNT_W'(CAP) - CNT_W'(in_neg);
      pad_r     <= in_item.pad_char;
      neg_r     <= in_neg;
    end else if (cmd.div_step) begin
      rem_value <= div_value;
      part_rem  <= cmd.div_last ? 4'd0 : div_rem;
    end
    if (issue) begin
      pend_last <= (char_count == CNT_W'(1));
    end
    if (load) begin
      out_item.char_out <= rd_data;
      out_item.last     <= pend_last;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load) begin
        char_count <= '0;
      end else if (wr_en) begin
        char_count <= char_count + 1'b1;
      end else if (issue) begin
        char_count <= cnt_dec;
      end
      if (issue) begin
        pend <= 1'b1;
      end else if (load) begin
        pend <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.value_zero  = (rem_value == '0);
  assign status.count_zero  = (char_count == '0);
  assign status.below_width = (char_count < width_r);
  assign status.negative    = neg_r;
  assign status.emit_done   = (char_count == '0) && !pend;

  // Store writes stay inside its depth
  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> char_count < CNT_W'(CAP))
    else $error("store write beyond depth");

  // Partial remainder stays below the base during division
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> {1'b0, part_rem} < base_r)
    else $error("partial remainder out of range");

  // No read left in flight when a new transaction is taken
  a_load_clean: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !pend && char_count == '0)
    else $error("new transaction while emitting");

endmodule

>>> hw/rtl/radix_integer_to_ascii_unit.sv
// Radix integer-to-ASCII unit.
// Input channel (in_valid/in_ready/in_item) takes one number per transaction:
// mode, 64-bit value, base, minimum width and pad character. Output channel
// (out_valid/out_ready/out_item) returns its characters most significant
// first, one per transaction, with last set on the final one.
// One number is converted at a time; in_ready is high only while idle.
// Conversion after acceptance: per digit a check state, then the restoring
// divider (8 quotient bits per cycle over 64 bits); after the last digit one
// more check state, then the pad state, one pad character per visit until
// the minimum width is met, and the sign state for a minus sign. Characters
// then leave at up to one per cycle from the digit store (registered read,
// one read kept ahead of the output register).
// A stalled receiver holds the output register and pauses store reads; the
// next number is accepted once the final character sits in that register.
// Reset (synchronous, active high) drops any conversion in progress and
// any character not yet taken; the store needs no clearing.
module radix_integer_to_ascii_unit
  import rca_pkg::*;
  #(
    parameter int MAX_CHARS = MAX_CHARS_DEF
  )
  (
    input  logic      clk,
    input  logic      rst,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
  );

  ctl_cmd_t   cmd;
  dp_status_t status;

  rca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rca_dpath #(
    .MAX_CHARS (MAX_CHARS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

>>> tb/ascii_digit_checker.sv
`timescale 1ns / 100ps

module ascii_digit_checker
  import rca_pkg::*;
  (
    input  logic      clk,
    input  logic      rst,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_item,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_item,
    output int        fail_count,
    output int        open_chars,
    output int        chars_checked
  );

  // Digit glyphs, index 0 in the top byte
  localparam logic [8*16-1:0] HEX_GLYPHS = "0123456789abcdef";
  localparam int STORE_ROOM = (MAX_CHARS_DEF < RESULT_LIMIT) ? MAX_CHARS_DEF : RESULT_LIMIT;

  out_item_t expected_chars[$];
  out_item_t want;

  // Work out the characters of one number and queue them in output order
  function automatic void predict_digits(input in_item_t num);
    logic [CHAR_W-1:0]  rev [0:RESULT_LIMIT-1];
    logic [VALUE_W-1:0] rest;
    logic [VALUE_W-1:0] radix;
    logic [VALUE_W-1:0] rem;
    int unsigned        room;
    int unsigned        goal;
    int unsigned        n;
    int                 idx;
    bit                 neg;
    out_item_t          ch;
    neg  = (num.mode == MODE_SIGNED) && num.value[VALUE_W-1];
    rest = neg ? (~num.value + 64'd1) : num.value;
    room = STORE_ROOM - (neg ? 1 : 0);
    if (num.mode == MODE_SIGNED) begin
      radix = VALUE_W'(BASE_DEC);
      goal  = 0;
    end else begin
      if (num.base < BASE_MIN) radix = VALUE_W'(BASE_MIN);
      else if (num.base > BASE_MAX) radix = VALUE_W'(BASE_MAX);
      else radix = VALUE_W'(num.base);
      goal = (32'(num.min_width) > room) ? room : 32'(num.min_width);
    end
    // digits go in least significant first
    n = 0;
    if (rest == '0) begin
      rev[0] = CHAR_ZERO;
      n = 1;
    end
    while (rest != '0) begin
      rem = rest % radix;
      if (n < room) begin
        idx = 15 - int'(rem[3:0]);
        rev[n] = HEX_GLYPHS[8*idx +: 8];
        n++;
      end
      rest = rest / radix;
    end
    while (n < goal) begin
      rev[n] = num.pad_char;
      n++;
    end
    if (neg) begin
      ch.char_out = CHAR_MINUS;
      ch.last     = 1'b0;
      expected_chars.push_back(ch);
    end
    while (n > 0) begin
      n--;
      ch.char_out = rev[n];
      ch.last     = (n == 0);
      expected_chars.push_back(ch);
    end
  endfunction

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what);
    $display("tb: mismatch at %0t ns: %s", $time, what);
    fail_count++;
  endtask

  // Predict on each input transaction, compare on each output transaction
  always @(posedge clk) begin
    if (rst) begin
      expected_chars.delete();
      fail_count     = 0;
      chars_checked <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_digits(in_item);
      end
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                    out_item.char_out, out_item.last));
        end else begin
          want = expected_chars.pop_front();
          if (out_item.char_out !== want.char_out) begin
            report_mismatch($sformatf("char 0x%02h, want 0x%02h",
                                      out_item.char_out, want.char_out));
          end
          if (out_item.last !== want.last) begin
            report_mismatch($sformatf("last %0b, want %0b on char 0x%02h",
                                      out_item.last, want.last, want.char_out));
          end
          chars_checked <= chars_checked + 1;
        end
      end
    end
    open_chars <= expected_chars.size();
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rca_pkg::*;

  localparam logic MODE_UNSIGNED = ~MODE_SIGNED;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int fail_count;
  int open_chars;
  int chars_checked;
  int numbers_sent  = 0;
  int signed_sent   = 0;
  int stall_left    = 0;
  bit quiet         = 1'b0;

  always #5 clk = ~clk;

  radix_integer_to_ascii_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  ascii_digit_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item      (out_item),
    .fail_count    (fail_count),
    .open_chars    (open_chars),
    .chars_checked (chars_checked)
  );

  // Receiver: stall in random bursts, none in the final stretch
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic in_item_t make_number(input logic mode, input logic [VALUE_W-1:0] value,
                                           input logic [BASE_W-1:0] base,
                                           input logic [WIDTH_W-1:0] width,
                                           input logic [CHAR_W-1:0] pad);
    in_item_t num;
    num.mode      = mode;
    num.value     = value;
    num.base      = base;
    num.min_width = width;
    num.pad_char  = pad;
    return num;
  endfunction

  // Mostly legal bases and modest widths, with full-range outliers
  function automatic in_item_t random_number();
    in_item_t           num;
    logic [VALUE_W-1:0] v;
    int                 pick;
    v    = {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    unique case (pick)
      0, 1: v = v >> $urandom_range(0, 63);
      2: v = 64'($urandom_range(0, 99));
      3: v = 64'd0 - 64'($urandom_range(1, 1000));
      default: ;
    endcase
    num.mode      = $urandom_range(0, 1) ? MODE_SIGNED : MODE_UNSIGNED;
    num.value     = v;
    num.base      = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                                : 5'($urandom_range(2, 16));
    num.min_width = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(0, 24));
    num.pad_char  = 8'($urandom);
    return num;
  endfunction

  // Offer one number, with an occasional idle burst ahead of it
  task automatic send_number(input in_item_t num);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= num;
    do @(posedge clk); while (!in_ready);
    numbers_sent++;
    if (num.mode == MODE_SIGNED) signed_sent++;
  endtask

  // Hold off the sender until every queued character has come back
  task automatic drain_chars();
    in_valid <= 1'b0;
    do @(posedge clk); while (open_chars != 0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: zero, extremes, base and width saturation, signed corners
    send_number(make_number(MODE_UNSIGNED, 64'd0, 5'd10, 7'd0, " "));
    send_number(make_number(MODE_UNSIGNED, 64'd0, 5'd16, 7'd5, "*"));
    send_number(make_number(MODE_UNSIGNED, '1, 5'd2, 7'd0, 8'h00));
    send_number(make_number(MODE_UNSIGNED, '1, 5'd16, 7'd0, 8'h00));
    send_number(make_number(MODE_UNSIGNED, '1, 5'd10, 7'd0, 8'h00));
    send_number(make_number(MODE_UNSIGNED, '1, 5'd3, 7'd0, 8'h00));
    send_number(make_number(MODE_UNSIGNED, 64'h8000_0000_0000_0000, 5'd2, 7'd64, "0"));
    send_number(make_number(MODE_UNSIGNED, 64'd5, 5'd0, 7'd0, " "));
    send_number(make_number(MODE_UNSIGNED, 64'd5, 5'd1, 7'd8, "0"));
    send_number(make_number(MODE_UNSIGNED, 64'd255, 5'd17, 7'd0, " "));
    send_number(make_number(MODE_UNSIGNED, 64'hdead_beef, 5'd31, 7'd12, 8'hff));
    send_number(make_number(MODE_UNSIGNED, 64'd7, 5'd10, 7'd65, "#"));
    send_number(make_number(MODE_UNSIGNED, 64'd7, 5'd10, 7'd127, 8'h00));
    send_number(make_number(MODE_UNSIGNED, 64'd12345678901234567890, 5'd10, 7'd20, "_"));
    send_number(make_number(MODE_UNSIGNED, 64'h0123_4567_89ab_cdef, 5'd16, 7'd16, "0"));
    send_number(make_number(MODE_UNSIGNED, 64'd1, 5'd7, 7'd1, "."));
    send_number(make_number(MODE_UNSIGNED, 64'd100, 5'd9, 7'd3, " "));
    send_number(make_number(MODE_SIGNED, 64'd0, 5'd0, 7'd0, 8'h00));
    send_number(make_number(MODE_SIGNED, 64'd1, 5'd31, 7'd127, 8'hff));
    send_number(make_number(MODE_SIGNED, '1, 5'd2, 7'd40, "x"));
    send_number(make_number(MODE_SIGNED, 64'h8000_0000_0000_0000, 5'd16, 7'd64, "0"));
    send_number(make_number(MODE_SIGNED, 64'h7fff_ffff_ffff_ffff, 5'd0, 7'd0, 8'h00));
    send_number(make_number(MODE_SIGNED, 64'd0 - 64'd12345, 5'd3, 7'd30, "z"));
    send_number(make_number(MODE_SIGNED, 64'd987654321, 5'd16, 7'd30, "*"));
    drain_chars();

    // random numbers, with full drains now and then and a quiet tail
    for (int k = 0; k < 300; k++) begin
      if (k == 100 || k == 200) drain_chars();
      if (k == 260) quiet = 1'b1;
      send_number(random_number());
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (open_chars != 0);
    repeat (20) @(posedge clk);

    $display("tb: %0d numbers converted (%0d signed), %0d characters compared",
             numbers_sent, signed_sent, chars_checked);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog on the whole run
  initial begin
    #15_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
